[sv/tld_pkg.sv]
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and codes for the tagged record deserializer.
// ----------------------------------------------------------------------------
package tld_pkg;

    // token kinds
    localparam logic [3:0] KIND_COUNT    = 4'd0;
    localparam logic [3:0] KIND_KEYLEN   = 4'd1;
    localparam logic [3:0] KIND_KEYBYTE  = 4'd2;
    localparam logic [3:0] KIND_BOOL     = 4'd3;
    localparam logic [3:0] KIND_INT      = 4'd4;
    localparam logic [3:0] KIND_FLOAT    = 4'd5;
    localparam logic [3:0] KIND_STRLEN   = 4'd6;
    localparam logic [3:0] KIND_STRBYTE  = 4'd7;
    localparam logic [3:0] KIND_ARRAYHDR = 4'd8;
    localparam logic [3:0] KIND_DONE     = 4'd9;
    localparam logic [3:0] KIND_ERROR    = 4'd10;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LIMIT = 2'd1;
    localparam logic [1:0] ERR_TAG   = 2'd2;

    // config register indexes
    localparam logic [2:0] REG_FIELD_LIMIT = 3'd0;
    localparam logic [2:0] REG_KEY_LIMIT   = 3'd1;
    localparam logic [2:0] REG_CODE_BOOL   = 3'd2;
    localparam logic [2:0] REG_CODE_INT    = 3'd3;
    localparam logic [2:0] REG_CODE_FLOAT  = 3'd4;
    localparam logic [2:0] REG_CODE_STRING = 3'd5;
    localparam logic [2:0] REG_CODE_ARRAY  = 3'd6;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic        in_array;
        logic [7:0]  field_number;
        logic [31:0] element_number;
        logic [1:0]  element_kind;
        logic [1:0]  error_code;
        logic        record_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  field_limit;
        logic [15:0] key_length_limit;
        logic [7:0]  code_boolean;
        logic [7:0]  code_integer;
        logic [7:0]  code_float;
        logic [7:0]  code_string;
        logic [7:0]  code_array;
    } t_cfg;

endpackage

[sv/tld_front.sv]
// ----------------------------------------------------------------------------
// tld_front
// Byte parser: classifies each byte of the record and builds at most one token per byte.
// ----------------------------------------------------------------------------
module tld_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tld_pkg::t_in_item  i_item,
    input  tld_pkg::t_cfg      i_cfg,
    output logic               o_tok_valid,
    output tld_pkg::t_out_item o_tok
);

    // parser phases; element phases carry PH_ELEM on top
    localparam logic [4:0] PH_COUNT    = 5'd0;
    localparam logic [4:0] PH_KEYLEN   = 5'd1;
    localparam logic [4:0] PH_KEY      = 5'd2;
    localparam logic [4:0] PH_TAG      = 5'd3;
    localparam logic [4:0] PH_BOOL     = 5'd4;
    localparam logic [4:0] PH_INT      = 5'd5;
    localparam logic [4:0] PH_FLT      = 5'd6;
    localparam logic [4:0] PH_SLEN     = 5'd7;
    localparam logic [4:0] PH_SBODY    = 5'd8;
    localparam logic [4:0] PH_ELTAG    = 5'd9;
    localparam logic [4:0] PH_ACOUNT   = 5'd10;
    localparam logic [4:0] PH_FINISHED = 5'd11;
    localparam logic [4:0] PH_ELEM     = 5'd16;

    logic [4:0]  r_phase, n_phase;
    logic [3:0]  r_bif, n_bif;
    logic [63:0] r_asm, n_asm;
    logic [7:0]  r_fields_left, n_fields_left;
    logic [7:0]  r_field_index, n_field_index;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_elems_left, n_elems_left;
    logic [31:0] r_elem_index, n_elem_index;
    logic [1:0]  r_array_kind, n_array_kind;
    logic        r_skipping, n_skipping;

    always_comb begin
        logic [7:0]  b;
        logic        fin;
        logic        arr;
        logic [4:0]  vp;
        logic [63:0] g_asm;
        logic [3:0]  g_cnt;
        logic        have, err, complete, vdone;
        logic [1:0]  ecode;
        logic [1:0]  k;
        logic        ok;
        logic [7:0]  t;
        logic [31:0] n32;
        b        = i_item.data_byte;
        fin      = i_item.final_byte;
        arr      = r_phase[4];
        vp       = {1'b0, r_phase[3:0]};
        g_asm    = r_asm | ({56'd0, b} << {r_bif[2:0], 3'b000});
        g_cnt    = r_bif + 4'd1;
        have     = 1'b0;
        err      = 1'b0;
        complete = 1'b0;
        vdone    = 1'b0;
        ecode    = tld_pkg::ERR_NONE;
        k        = 2'd0;
        ok       = 1'b1;
        t        = 8'd0;
        n32      = 32'd0;

        n_phase       = r_phase;
        n_bif         = r_bif;
        n_asm         = r_asm;
        n_fields_left = r_fields_left;
        n_field_index = r_field_index;
        n_bytes_left  = r_bytes_left;
        n_elems_left  = r_elems_left;
        n_elem_index  = r_elem_index;
        n_array_kind  = r_array_kind;
        n_skipping    = r_skipping;

        o_tok                = '0;
        o_tok.field_number   = r_field_index;
        o_tok.in_array       = arr;
        o_tok.element_number = arr ? r_elem_index : 32'd0;
        o_tok.element_kind   = arr ? r_array_kind : 2'd0;

        if (r_skipping) begin
            // drop bytes until the buffer ends
            if (fin) begin
                n_skipping = 1'b0;
                n_phase    = PH_COUNT;
            end
        end else if (r_phase == PH_FINISHED) begin
            if (fin) begin
                have               = 1'b1;
                o_tok.kind         = tld_pkg::KIND_DONE;
                o_tok.in_array     = 1'b0;
                o_tok.element_number = 32'd0;
                o_tok.element_kind = 2'd0;
                o_tok.record_end   = 1'b1;
                n_phase            = PH_COUNT;
            end
        end else begin
            unique case (vp)
                PH_COUNT: begin
                    n_asm = g_asm;
                    n_bif = g_cnt;
                    if (g_cnt >= 4'd4) begin
                        n_asm = '0;
                        n_bif = '0;
                        if (g_asm[31:0] > {24'd0, i_cfg.field_limit}) begin
                            err   = 1'b1;
                            ecode = tld_pkg::ERR_LIMIT;
                        end else begin
                            have          = 1'b1;
                            o_tok.kind    = tld_pkg::KIND_COUNT;
                            o_tok.value   = {32'd0, g_asm[31:0]};
                            n_fields_left = g_asm[7:0];
                            n_field_index = 8'd0;
                            o_tok.field_number = 8'd0;
                            if (g_asm[31:0] == 32'd0) begin
                                n_phase  = PH_FINISHED;
                                complete = 1'b1;
                            end else begin
                                n_phase = PH_KEYLEN;
                            end
                        end
                    end
                end
                PH_KEYLEN: begin
                    n_asm = g_asm;
                    n_bif = g_cnt;
                    if (g_cnt >= 4'd2) begin
                        n_asm = '0;
                        n_bif = '0;
                        if (g_asm[15:0] > i_cfg.key_length_limit) begin
                            err   = 1'b1;
                            ecode = tld_pkg::ERR_LIMIT;
                        end else begin
                            have         = 1'b1;
                            o_tok.kind   = tld_pkg::KIND_KEYLEN;
                            o_tok.value  = {48'd0, g_asm[15:0]};
                            n_bytes_left = {16'd0, g_asm[15:0]};
                            n_phase      = (g_asm[15:0] == 16'd0) ? PH_TAG : PH_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    have         = 1'b1;
                    o_tok.kind   = tld_pkg::KIND_KEYBYTE;
                    o_tok.value  = {56'd0, b};
                    n_bytes_left = r_bytes_left - 32'd1;
                    if (n_bytes_left == 32'd0) n_phase = PH_TAG;
                end
                PH_TAG: begin
                    if (b == i_cfg.code_boolean)     n_phase = PH_BOOL;
                    else if (b == i_cfg.code_integer) n_phase = PH_INT;
                    else if (b == i_cfg.code_float)   n_phase = PH_FLT;
                    else if (b == i_cfg.code_string)  n_phase = PH_SLEN;
                    else if (b == i_cfg.code_array)   n_phase = PH_ELTAG;
                    else begin
                        err   = 1'b1;
                        ecode = tld_pkg::ERR_TAG;
                    end
                end
                PH_BOOL: begin
                    have        = 1'b1;
                    o_tok.kind  = tld_pkg::KIND_BOOL;
                    o_tok.value = {63'd0, (b != 8'd0)};
                    vdone       = 1'b1;
                end
                PH_INT, PH_FLT: begin
                    n_asm = g_asm;
                    n_bif = g_cnt;
                    if (g_cnt >= 4'd8) begin
                        n_asm       = '0;
                        n_bif       = '0;
                        have        = 1'b1;
                        o_tok.kind  = (vp == PH_INT) ? tld_pkg::KIND_INT
                                                     : tld_pkg::KIND_FLOAT;
                        o_tok.value = g_asm;
                        vdone       = 1'b1;
                    end
                end
                PH_SLEN: begin
                    n_asm = g_asm;
                    n_bif = g_cnt;
                    if (g_cnt >= 4'd4) begin
                        n_asm       = '0;
                        n_bif       = '0;
                        have        = 1'b1;
                        o_tok.kind  = tld_pkg::KIND_STRLEN;
                        o_tok.value = {32'd0, g_asm[31:0]};
                        if (g_asm[31:0] == 32'd0) begin
                            vdone = 1'b1;
                        end else begin
                            n_bytes_left = g_asm[31:0];
                            n_phase      = arr ? (PH_SBODY + PH_ELEM) : PH_SBODY;
                        end
                    end
                end
                PH_SBODY: begin
                    have         = 1'b1;
                    o_tok.kind   = tld_pkg::KIND_STRBYTE;
                    o_tok.value  = {56'd0, b};
                    n_bytes_left = r_bytes_left - 32'd1;
                    if (n_bytes_left == 32'd0) vdone = 1'b1;
                end
                PH_ELTAG: begin
                    n_asm   = {24'd0, b, 32'd0};
                    n_bif   = '0;
                    n_phase = PH_ACOUNT;
                end
                PH_ACOUNT: begin
                    n_asm = g_asm;
                    n_bif = g_cnt;
                    if (g_cnt >= 4'd4) begin
                        n_asm = '0;
                        n_bif = '0;
                        n32   = g_asm[31:0];
                        t     = g_asm[39:32];
                        if (t == i_cfg.code_boolean)      k = 2'd0;
                        else if (t == i_cfg.code_integer) k = 2'd1;
                        else if (t == i_cfg.code_float)   k = 2'd2;
                        else if (t == i_cfg.code_string)  k = 2'd3;
                        else ok = 1'b0;
                        if (!ok && n32 != 32'd0) begin
                            err   = 1'b1;
                            ecode = tld_pkg::ERR_TAG;
                        end else begin
                            n_array_kind       = k;
                            n_elems_left       = n32;
                            n_elem_index       = 32'd0;
                            have               = 1'b1;
                            o_tok.kind         = tld_pkg::KIND_ARRAYHDR;
                            o_tok.value        = {32'd0, n32};
                            o_tok.in_array     = 1'b0;
                            o_tok.element_number = 32'd0;
                            o_tok.element_kind = k;
                            if (n32 == 32'd0) begin
                                n_field_index = r_field_index + 8'd1;
                                n_fields_left = r_fields_left - 8'd1;
                                if (n_fields_left == 8'd0) begin
                                    n_phase  = PH_FINISHED;
                                    complete = 1'b1;
                                end else begin
                                    n_phase = PH_KEYLEN;
                                end
                            end else begin
                                n_phase = PH_ELEM + PH_BOOL + {3'd0, k};
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            // end of one value: next element, next field or record finish
            if (vdone) begin
                if (arr && (r_elems_left != 32'd1)) begin
                    n_elem_index = r_elem_index + 32'd1;
                    n_elems_left = r_elems_left - 32'd1;
                    n_phase      = PH_ELEM + PH_BOOL + {3'd0, r_array_kind};
                end else begin
                    if (arr) begin
                        n_elem_index = r_elem_index + 32'd1;
                        n_elems_left = r_elems_left - 32'd1;
                    end
                    n_field_index = r_field_index + 8'd1;
                    n_fields_left = r_fields_left - 8'd1;
                    if (n_fields_left == 8'd0) begin
                        n_phase  = PH_FINISHED;
                        complete = 1'b1;
                    end else begin
                        n_phase = PH_KEYLEN;
                    end
                end
            end

            // last byte or error closes the record
            if (fin || err) begin
                have = 1'b1;
                if (err || !complete) begin
                    o_tok                = '0;
                    o_tok.kind           = tld_pkg::KIND_ERROR;
                    o_tok.error_code     = err ? ecode : tld_pkg::ERR_LIMIT;
                    o_tok.record_end     = 1'b1;
                    o_tok.field_number   = n_field_index;
                end else begin
                    o_tok.record_end = 1'b1;
                end
                if (fin) n_phase = PH_COUNT;
                else     n_skipping = 1'b1;
            end
        end

        // a last byte always returns to a clean record start
        if (fin && (n_phase == PH_COUNT)) begin
            n_bif         = '0;
            n_asm         = '0;
            n_fields_left = '0;
            n_field_index = '0;
            n_bytes_left  = '0;
            n_elems_left  = '0;
            n_elem_index  = '0;
            n_array_kind  = '0;
            n_skipping    = 1'b0;
        end

        o_tok_valid = i_valid && have;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_COUNT;
            r_bif         <= '0;
            r_asm         <= '0;
            r_fields_left <= '0;
            r_field_index <= '0;
            r_bytes_left  <= '0;
            r_elems_left  <= '0;
            r_elem_index  <= '0;
            r_array_kind  <= '0;
            r_skipping    <= 1'b0;
        end else if (i_valid) begin
            r_phase       <= n_phase;
            r_bif         <= n_bif;
            r_asm         <= n_asm;
            r_fields_left <= n_fields_left;
            r_field_index <= n_field_index;
            r_bytes_left  <= n_bytes_left;
            r_elems_left  <= n_elems_left;
            r_elem_index  <= n_elem_index;
            r_array_kind  <= n_array_kind;
            r_skipping    <= n_skipping;
        end
    end

endmodule

[sv/tld_fifo.sv]
// ----------------------------------------------------------------------------
// tld_fifo
// Short token queue between the parser and the result port.
// ----------------------------------------------------------------------------
module tld_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  tld_pkg::t_out_item i_data,
    input  logic               i_rd,
    output logic               o_full,
    output logic               o_empty,
    output tld_pkg::t_out_item o_data
);

    localparam int PW = $clog2(tld_pkg::FIFO_DEPTH);

    tld_pkg::t_out_item r_mem [tld_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == (PW+1)'(tld_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_data;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end

endmodule

[sv/tagged_record_deserializer.sv]
// ----------------------------------------------------------------------------
// tagged_record_deserializer
// Tag-length-value record decoder, one byte in, at most one token out.
// ----------------------------------------------------------------------------
// Input: one byte word per push while full is low. Output: token words
// wait in a four-entry queue; the oldest is on o_out_item while empty is
// low and leaves on pop. A byte that makes a token is parsed in the cycle
// it is pushed and its token is visible the next cycle. Throughput is one
// byte per cycle, set by the combinational parser; full rises only when the
// token queue is full, so a stalled receiver backs up into the byte side
// after four tokens. Configuration goes through the APB port (limits and
// tag codes at byte addresses 0..24). The user must see that configuration
// is written only while the block is idle; the block itself does not enforce
// this. Reset (i_rst_n low, synchronous) empties the queue, sets the parser
// to expect a field count and loads the default limits and tag codes.
// ----------------------------------------------------------------------------
module tagged_record_deserializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tld_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output tld_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tld_pkg::t_cfg      r_cfg;
    tld_pkg::t_out_item w_tok;
    logic               w_tok_valid;
    logic               w_accept;
    logic [2:0]         w_idx;

    assign pready   = 1'b1;
    assign w_idx    = paddr[4:2];
    assign w_accept = push && !full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_limit      <= 8'd32;
            r_cfg.key_length_limit <= 16'd64;
            r_cfg.code_boolean     <= 8'd1;
            r_cfg.code_integer     <= 8'd2;
            r_cfg.code_float       <= 8'd3;
            r_cfg.code_string      <= 8'd4;
            r_cfg.code_array       <= 8'd5;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                tld_pkg::REG_FIELD_LIMIT: r_cfg.field_limit      <= pwdata[7:0];
                tld_pkg::REG_KEY_LIMIT:   r_cfg.key_length_limit <= pwdata[15:0];
                tld_pkg::REG_CODE_BOOL:   r_cfg.code_boolean     <= pwdata[7:0];
                tld_pkg::REG_CODE_INT:    r_cfg.code_integer     <= pwdata[7:0];
                tld_pkg::REG_CODE_FLOAT:  r_cfg.code_float       <= pwdata[7:0];
                tld_pkg::REG_CODE_STRING: r_cfg.code_string      <= pwdata[7:0];
                tld_pkg::REG_CODE_ARRAY:  r_cfg.code_array       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_idx)
            tld_pkg::REG_FIELD_LIMIT: prdata = {24'd0, r_cfg.field_limit};
            tld_pkg::REG_KEY_LIMIT:   prdata = {16'd0, r_cfg.key_length_limit};
            tld_pkg::REG_CODE_BOOL:   prdata = {24'd0, r_cfg.code_boolean};
            tld_pkg::REG_CODE_INT:    prdata = {24'd0, r_cfg.code_integer};
            tld_pkg::REG_CODE_FLOAT:  prdata = {24'd0, r_cfg.code_float};
            tld_pkg::REG_CODE_STRING: prdata = {24'd0, r_cfg.code_string};
            tld_pkg::REG_CODE_ARRAY:  prdata = {24'd0, r_cfg.code_array};
            default:                  prdata = 32'd0;
        endcase
    end

    tld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_item      (i_in_item),
        .i_cfg       (r_cfg),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok)
    );

    tld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_tok_valid),
        .i_data  (w_tok),
        .i_rd    (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (o_out_item)
    );

endmodule

[dv/tld_checker.sv]
// ----------------------------------------------------------------------------
// tld_checker
// Watches the byte, token and register ports of the record deserializer,
// predicts each token from the accepted bytes and compares field by field.
// ----------------------------------------------------------------------------
module tld_checker
    import tld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  logic      full,
    input  t_in_item  i_in_item,
    input  logic      empty,
    input  logic      pop,
    input  t_out_item i_out_item,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic      pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int        o_fail_count,
    output int        o_pending
);

    // parser phases; element phases sit at an offset
    localparam logic [4:0] P_COUNT    = 5'd0;
    localparam logic [4:0] P_KEYLEN   = 5'd1;
    localparam logic [4:0] P_KEY      = 5'd2;
    localparam logic [4:0] P_TAG      = 5'd3;
    localparam logic [4:0] P_BOOL     = 5'd4;
    localparam logic [4:0] P_INT      = 5'd5;
    localparam logic [4:0] P_FLT      = 5'd6;
    localparam logic [4:0] P_SLEN     = 5'd7;
    localparam logic [4:0] P_SBODY    = 5'd8;
    localparam logic [4:0] P_ELTAG    = 5'd9;
    localparam logic [4:0] P_ACOUNT   = 5'd10;
    localparam logic [4:0] P_FINISHED = 5'd11;
    localparam logic [4:0] P_ELEM     = 5'd16;

    localparam logic [1:0] EK_BOOL = 2'd0;
    localparam logic [1:0] EK_INT  = 2'd1;
    localparam logic [1:0] EK_FLT  = 2'd2;
    localparam logic [1:0] EK_STR  = 2'd3;

    t_cfg        cfg;
    logic [4:0]  ph;
    int unsigned nbyte;
    logic [63:0] acc;
    logic [7:0]  flds_left, fld_idx;
    logic [31:0] blen, elems_left, elem_idx;
    logic [1:0]  arr_kind;
    logic        skip;
    t_out_item   tok;
    t_out_item   expected_tokens[$];

    function automatic void clear_parser();
        ph = P_COUNT; nbyte = 0; acc = '0; flds_left = '0; fld_idx = '0;
        blen = '0; elems_left = '0; elem_idx = '0; arr_kind = EK_BOOL; skip = 1'b0;
    endfunction

    function automatic void make_tok(logic [3:0] k, logic [63:0] v, logic arr);
        tok = '0;
        tok.kind = k; tok.value = v; tok.in_array = arr;
        tok.field_number = fld_idx;
        tok.element_number = arr ? elem_idx : '0;
        tok.element_kind = arr ? arr_kind : EK_BOOL;
        tok.error_code = ERR_NONE;
    endfunction

    function automatic void make_err(logic [1:0] code);
        make_tok(KIND_ERROR, '0, 1'b0);
        tok.error_code = code;
        tok.record_end = 1'b1;
    endfunction

    // little-endian assembly of a multi-byte word
    function automatic bit collect(logic [7:0] b, int unsigned n, output logic [63:0] w);
        acc |= 64'(b) << (8 * (nbyte & 7));
        nbyte++;
        w = acc;
        if (nbyte < n) return 0;
        acc = '0; nbyte = 0;
        return 1;
    endfunction

    function automatic bit field_done();
        fld_idx++;
        flds_left--;
        if (flds_left == 0) begin
            ph = P_FINISHED;
            return 1;
        end
        ph = P_KEYLEN;
        return 0;
    endfunction

    function automatic bit value_done(logic arr);
        if (!arr) return field_done();
        elem_idx++;
        elems_left--;
        if (elems_left == 0) return field_done();
        ph = P_ELEM + P_BOOL + 5'(arr_kind);
        return 0;
    endfunction

    // one byte through the decoder; returns 1 when it yields a token
    function automatic bit decode_byte(t_in_item it);
        logic [7:0]  b;
        logic        fin, have, err, complete, arr, ok;
        logic [4:0]  vp;
        logic [63:0] w;
        logic [1:0]  k;
        b = it.data_byte; fin = it.final_byte;
        have = 0; err = 0; complete = 0;
        if (skip) begin
            if (fin) clear_parser();
            return 0;
        end
        if (ph == P_FINISHED) begin
            if (!fin) return 0;
            make_tok(KIND_DONE, '0, 1'b0);
            tok.record_end = 1'b1;
            clear_parser();
            return 1;
        end
        arr = ph >= P_ELEM;
        vp = arr ? ph - P_ELEM : ph;
        case (vp)
            P_COUNT: if (collect(b, 4, w)) begin
                w &= 64'hffff_ffff;
                if (w > 64'(cfg.field_limit)) begin
                    make_err(ERR_LIMIT); err = 1;
                end else begin
                    flds_left = w[7:0]; fld_idx = '0;
                    make_tok(KIND_COUNT, w, 1'b0); have = 1;
                    if (w == 0) begin
                        ph = P_FINISHED; complete = 1;
                    end else ph = P_KEYLEN;
                end
            end
            P_KEYLEN: if (collect(b, 2, w)) begin
                w &= 64'hffff;
                if (w > 64'(cfg.key_length_limit)) begin
                    make_err(ERR_LIMIT); err = 1;
                end else begin
                    make_tok(KIND_KEYLEN, w, 1'b0); have = 1;
                    blen = w[31:0];
                    ph = (w == 0) ? P_TAG : P_KEY;
                end
            end
            P_KEY: begin
                make_tok(KIND_KEYBYTE, 64'(b), 1'b0); have = 1;
                blen--;
                if (blen == 0) ph = P_TAG;
            end
            P_TAG: begin
                if (b == cfg.code_boolean) ph = P_BOOL;
                else if (b == cfg.code_integer) ph = P_INT;
                else if (b == cfg.code_float) ph = P_FLT;
                else if (b == cfg.code_string) ph = P_SLEN;
                else if (b == cfg.code_array) ph = P_ELTAG;
                else begin
                    make_err(ERR_TAG); err = 1;
                end
            end
            P_BOOL: begin
                make_tok(KIND_BOOL, 64'(b != 0), arr); have = 1;
                complete = value_done(arr);
            end
            P_INT, P_FLT: if (collect(b, 8, w)) begin
                make_tok(vp == P_INT ? KIND_INT : KIND_FLOAT, w, arr); have = 1;
                complete = value_done(arr);
            end
            P_SLEN: if (collect(b, 4, w)) begin
                w &= 64'hffff_ffff;
                make_tok(KIND_STRLEN, w, arr); have = 1;
                if (w == 0) complete = value_done(arr);
                else begin
                    blen = w[31:0];
                    ph = arr ? P_ELEM + P_SBODY : P_SBODY;
                end
            end
            P_SBODY: begin
                make_tok(KIND_STRBYTE, 64'(b), arr); have = 1;
                blen--;
                if (blen == 0) complete = value_done(arr);
            end
            P_ELTAG: begin
                acc = 64'(b) << 32;
                nbyte = 0;
                ph = P_ACOUNT;
            end
            P_ACOUNT: if (collect(b, 4, w)) begin
                ok = 1; k = EK_BOOL;
                if (w[39:32] == cfg.code_boolean) k = EK_BOOL;
                else if (w[39:32] == cfg.code_integer) k = EK_INT;
                else if (w[39:32] == cfg.code_float) k = EK_FLT;
                else if (w[39:32] == cfg.code_string) k = EK_STR;
                else ok = 0;
                if (!ok && w[31:0] != 0) begin
                    make_err(ERR_TAG); err = 1;
                end else begin
                    arr_kind = k; elems_left = w[31:0]; elem_idx = '0;
                    make_tok(KIND_ARRAYHDR, 64'(w[31:0]), 1'b0);
                    tok.element_kind = k;
                    have = 1;
                    if (w[31:0] == 0) complete = field_done();
                    else ph = P_ELEM + P_BOOL + 5'(k);
                end
            end
            default: ;
        endcase
        if (fin) begin
            if (!err) begin
                if (complete) tok.record_end = 1'b1;
                else make_err(ERR_LIMIT);
            end
            have = 1;
            clear_parser();
        end else if (err) begin
            have = 1;
            skip = 1'b1;
        end
        return have;
    endfunction

    function automatic void compare_token(t_out_item e, t_out_item a);
        if (a.kind != e.kind)
            $error("kind: expected %0d, got %0d", e.kind, a.kind);
        if (a.value != e.value)
            $error("value: expected %0h, got %0h", e.value, a.value);
        if (a.in_array != e.in_array)
            $error("in_array: expected %0d, got %0d", e.in_array, a.in_array);
        if (a.field_number != e.field_number)
            $error("field_number: expected %0d, got %0d", e.field_number, a.field_number);
        if (a.element_number != e.element_number)
            $error("element_number: expected %0d, got %0d", e.element_number,
                   a.element_number);
        if (a.element_kind != e.element_kind)
            $error("element_kind: expected %0d, got %0d", e.element_kind, a.element_kind);
        if (a.error_code != e.error_code)
            $error("error_code: expected %0d, got %0d", e.error_code, a.error_code);
        if (a.record_end != e.record_end)
            $error("record_end: expected %0d, got %0d", e.record_end, a.record_end);
        if (a != e) o_fail_count++;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    // all ports are driven at the falling edge, so sampling here is stable
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{8'd32, 16'd64, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
            clear_parser();
            expected_tokens.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_tokens.size() == 0) begin
                    $error("token word with no expectation: kind %0d", i_out_item.kind);
                    o_fail_count++;
                end else compare_token(expected_tokens.pop_front(), i_out_item);
            end
            if (push && !full && decode_byte(i_in_item))
                expected_tokens.push_back(tok);
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_FIELD_LIMIT: cfg.field_limit      = pwdata[7:0];
                    REG_KEY_LIMIT:   cfg.key_length_limit = pwdata[15:0];
                    REG_CODE_BOOL:   cfg.code_boolean     = pwdata[7:0];
                    REG_CODE_INT:    cfg.code_integer     = pwdata[7:0];
                    REG_CODE_FLOAT:  cfg.code_float       = pwdata[7:0];
                    REG_CODE_STRING: cfg.code_string      = pwdata[7:0];
                    REG_CODE_ARRAY:  cfg.code_array       = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_tokens.size();
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives serialized records into the deserializer under several register
// settings: directed corner records, then random well-formed, truncated,
// corrupted, padded and noise records. Token checking lives in tld_checker.
// ----------------------------------------------------------------------------
module testbench;
    import tld_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        i_clk, i_rst_n;
    logic        push, full, empty, pop;
    t_in_item    i_in_item;
    t_out_item   o_out_item;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending;

    // current settings as the generator sees them
    logic [7:0]  lim_fields;
    logic [15:0] lim_key;
    logic [7:0]  codes[5];
    logic        steady;
    int          bytes_sent, stall_cycles;
    logic [7:0]  stream[$];

    tagged_record_deserializer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_item(i_in_item), .empty(empty), .pop(pop), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tld_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_item(i_in_item), .empty(empty), .pop(pop), .i_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stalls except in steady stretches
    always @(negedge i_clk)
        pop <= steady || ($urandom_range(99) >= 23);

    // watchdog on cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        if (!steady)
            while ($urandom_range(99) < 23) begin
                push <= 1'b0;
                @(negedge i_clk);
            end
        push <= 1'b1;
        i_in_item <= '{b, fin};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // whole buffer, last byte flagged final
    task automatic send_stream();
        foreach (stream[i]) send_byte(stream[i], i == stream.size() - 1);
        push <= 1'b0;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(logic [7:0] fl, logic [15:0] kl, logic [7:0] c0,
                             logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                             logic [7:0] c4);
        wait_drained();
        reg_write(REG_FIELD_LIMIT, 32'(fl));
        reg_write(REG_KEY_LIMIT, 32'(kl));
        reg_write(REG_CODE_BOOL, 32'(c0));
        reg_write(REG_CODE_INT, 32'(c1));
        reg_write(REG_CODE_FLOAT, 32'(c2));
        reg_write(REG_CODE_STRING, 32'(c3));
        reg_write(REG_CODE_ARRAY, 32'(c4));
        lim_fields = fl; lim_key = kl;
        codes = '{c0, c1, c2, c3, c4};
    endtask

    function automatic void put_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) stream.push_back(v[8*i +: 8]);
    endfunction

    function automatic int short_len();
        return ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
    endfunction

    // untagged value body; sel 0 bool, 1 int, 2 float, 3 string
    function automatic void put_body(int sel);
        int n;
        case (sel)
            0: stream.push_back($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(1)));
            1, 2: put_le({$urandom, $urandom}, 8);
            default: begin
                n = short_len();
                put_le(64'(n), 4);
                repeat (n) stream.push_back(8'($urandom));
            end
        endcase
    endfunction

    function automatic void build_record();
        int nf, kl, sel, es, ne;
        nf = (lim_fields == 0) ? 0 : $urandom_range(lim_fields < 4 ? lim_fields : 4);
        put_le(64'(nf), 4);
        repeat (nf) begin
            kl = short_len();
            if (kl > lim_key) kl = lim_key;
            put_le(64'(kl), 2);
            repeat (kl) stream.push_back(8'($urandom));
            sel = $urandom_range(4);
            stream.push_back(codes[sel]);
            if (sel < 4) put_body(sel);
            else begin
                es = $urandom_range(3);
                ne = $urandom_range(3);
                stream.push_back(codes[es]);
                put_le(64'(ne), 4);
                repeat (ne) put_body(es);
            end
        end
    endfunction

    // mostly good records; some truncated, corrupted, padded or pure noise
    task automatic random_records(int quota);
        int mode, cut;
        while (bytes_sent < quota) begin
            stream.delete();
            mode = $urandom_range(99);
            if (mode < 8) repeat ($urandom_range(8, 1)) stream.push_back(8'($urandom));
            else begin
                build_record();
                if (mode < 18) begin
                    cut = $urandom_range(stream.size() - 1, 1);
                    while (stream.size() > cut) void'(stream.pop_back());
                end else if (mode < 30)
                    stream[$urandom_range(stream.size() - 1)] = 8'($urandom);
                else if (mode < 45)
                    repeat ($urandom_range(3, 1)) stream.push_back(8'($urandom));
            end
            send_stream();
        end
    endtask

    initial begin
        i_rst_n = 1'b0; push = 1'b0; i_in_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        steady = 1'b0; bytes_sent = 0; stall_cycles = 0;
        lim_fields = 8'd32; lim_key = 16'd64; codes = '{1, 2, 3, 4, 5};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty record ended on its count, and one closed by a done word
        stream = '{0, 0, 0, 0}; send_stream();
        stream = '{0, 0, 0, 0, 8'hAA}; send_stream();
        // field count and key length over their limits
        stream = '{33, 0, 0, 0, 1, 2}; send_stream();
        stream = '{1, 0, 0, 0, 65, 0, 9}; send_stream();
        // boolean from a nonzero byte, completed by the last byte
        stream = '{1, 0, 0, 0, 1, 0, 8'h61, 1, 8'hFF}; send_stream();
        // unknown tag mid-stream and on the last byte
        stream = '{1, 0, 0, 0, 0, 0, 8'h77, 5}; send_stream();
        stream = '{1, 0, 0, 0, 0, 0, 8'h77}; send_stream();
        // last byte arrives inside an integer
        stream = '{1, 0, 0, 0, 0, 0, 2, 1, 2, 3}; send_stream();
        // empty array with unknown element tag, nonempty array of arrays
        stream = '{1, 0, 0, 0, 0, 0, 5, 8'h99, 0, 0, 0, 0}; send_stream();
        stream = '{1, 0, 0, 0, 0, 0, 5, 5, 1, 0, 0, 0, 7}; send_stream();
        // one of every value type
        stream = '{5, 0, 0, 0, 0, 0, 1, 0, 0, 0, 2, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 3, 1, 2, 3, 4, 5, 6, 7, 8,
                   0, 0, 4, 2, 0, 0, 0, 8'h41, 8'h42,
                   0, 0, 5, 4, 2, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
        send_stream();

        random_records(220);
        configure(8'd255, 16'hFFFF, 8'd0, 8'd255, 8'd128, 8'd127, 8'd1);
        random_records(320);
        // sender holds off until every token is back
        wait (pending == 0);
        configure(8'd0, 16'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5);
        random_records(370);
        configure(8'd4, 16'd3, 8'd7, 8'd7, 8'd9, 8'd200, 8'd201);
        random_records(450);
        configure(8'd32, 16'd64, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5);
        steady = 1'b1;
        random_records(560);
        steady = 1'b0;
        random_records(650);

        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
